// ----- hw/rtl/imu_collision_detector_core_defines.svh -----
// ---------------------------------------------------------------------------
// IMU collision detector assertion macros
// Concurrent assertion helpers; compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef IMU_COLLISION_DETECTOR_CORE_DEFINES_SVH
`define IMU_COLLISION_DETECTOR_CORE_DEFINES_SVH

`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define IMUCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in the cycle after the antecedent.
`define IMUCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `IMUCD_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define IMUCD_ASSERT(lbl, prop, msg)
`define IMUCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/imucd_pkg.sv -----
// ---------------------------------------------------------------------------
// IMU collision detector package
// Register indexes, reset values, shock codes and the result layout.
// ---------------------------------------------------------------------------
package imucd_pkg;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL_OFFSET = 3'd0,
    CFG_ACCEL_SHOCK  = 3'd1,
    CFG_ACCEL_BLOCK  = 3'd2,
    CFG_GYRO_SHOCK   = 3'd3,
    CFG_YAW_GAIN     = 3'd4,
    CFG_BLOCK_WAIT   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SHOCK_NONE  = 2'b00,
    SHOCK_RIGHT = 2'b01,
    SHOCK_LEFT  = 2'b10,
    SHOCK_FRONT = 2'b11
  } shock_e;

  localparam logic signed [10:0] AccelOffsetRst = 11'sd0;
  localparam logic signed [13:0] AccelShockRst  = -14'sd200;
  localparam logic signed [13:0] AccelBlockRst  = 14'sd40;
  localparam logic [17:0]        GyroShockRst   = 18'd100;
  localparam logic [17:0]        YawGainRst     = 18'd3277;
  localparam logic [3:0]         BlockWaitRst   = 4'd6;

  localparam logic [3:0] SampleCntMax = 4'd15;

  // floor(x / 100) == (x * Div100Magic) >> Div100Shift for any 32-bit x
  localparam logic [31:0] Div100Magic = 32'h51EB_851F;
  localparam int unsigned Div100Shift = 37;
  localparam int unsigned YawQuotW    = 25;

  localparam logic signed [31:0] YawAccMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] YawAccMin = 32'sh8000_0000;

  // result item, first field in the high bits
  typedef struct packed {
    logic signed [13:0] min_accel;
    logic [12:0]        max_accel;
    logic signed [25:0] yaw_degrees;
    logic               blocked;
    shock_e             shock_code;
  } result_t;

endpackage

// ----- hw/rtl/imu_collision_detector_core.sv -----
// ---------------------------------------------------------------------------
// IMU collision detector core
// Yaw integration, acceleration extremes, shock and blocked detection.
// ---------------------------------------------------------------------------
// One request in, one result out. A sample request carries forward
// acceleration (1/100 m/s^2) and yaw rate (1/100 deg/s); a begin request
// (tuser = 1) clears yaw, extremes, shock code, blocked flag and sample
// count. Every request returns the state left after it. The block is a
// five-register pipeline (input, step multiply, state update, divide by
// 100, output) and takes one request per clock unless the output stalls.
// The yaw accumulator, the extremes and the latches close their loop in the
// single state-update stage, which is what lets requests follow back to
// back. The 19x18 step-angle multiply and the 32x32 reciprocal multiply for
// the divide by 100 each sit alone between registers. Backpressure ripples
// back through per-stage ready terms, so the input keeps taking requests while
// a result waits, until every stage is full. The user writes configuration
// only while the pipeline is empty; the block does not enforce it.
// ---------------------------------------------------------------------------
`include "imu_collision_detector_core_defines.svh"

module imu_collision_detector_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [imucd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [imucd_pkg::CfgDataW-1:0] cfg_data_i,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [imucd_pkg::InDataW-1:0]  s_axis_tdata,  // accel_forward[12:0], yaw_rate[31:13]
  input  logic                           s_axis_tuser,  // cmd
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [imucd_pkg::OutDataW-1:0] m_axis_tdata   // shock_code[1:0], blocked[2],
                                                        // yaw_degrees[28:3],
                                                        // max_accel[41:29],
                                                        // min_accel[55:42]
);
  import imucd_pkg::*;

  // ---------------- configuration registers ----------------
  logic signed [10:0] accel_offset_q;
  logic signed [13:0] accel_shock_q;
  logic signed [13:0] accel_block_q;
  logic [17:0]        gyro_shock_q;
  logic [17:0]        yaw_gain_q;
  logic [3:0]         block_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_offset_q <= AccelOffsetRst;
      accel_shock_q  <= AccelShockRst;
      accel_block_q  <= AccelBlockRst;
      gyro_shock_q   <= GyroShockRst;
      yaw_gain_q     <= YawGainRst;
      block_wait_q   <= BlockWaitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACCEL_OFFSET: accel_offset_q <= cfg_data_i[10:0];
        CFG_ACCEL_SHOCK:  accel_shock_q  <= cfg_data_i[13:0];
        CFG_ACCEL_BLOCK:  accel_block_q  <= cfg_data_i[13:0];
        CFG_GYRO_SHOCK:   gyro_shock_q   <= cfg_data_i;
        CFG_YAW_GAIN:     yaw_gain_q     <= cfg_data_i;
        CFG_BLOCK_WAIT:   block_wait_q   <= cfg_data_i[3:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------- handshake chain ----------------
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, m_valid_q;
  logic b_ready, c_ready, d_ready, e_ready;
  logic in_fire, b_load, c_load, d_load, e_load;

  assign e_ready       = !m_valid_q || m_axis_tready;
  assign d_ready       = !d_valid_q || e_ready;
  assign c_ready       = !c_valid_q || d_ready;
  assign b_ready       = !b_valid_q || c_ready;
  assign s_axis_tready = !a_valid_q || b_ready;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign b_load  = b_ready && a_valid_q;
  assign c_load  = c_ready && b_valid_q;
  assign d_load  = d_ready && c_valid_q;
  assign e_load  = e_ready && d_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) a_valid_q <= s_axis_tvalid;
      if (b_ready)       b_valid_q <= a_valid_q;
      if (c_ready)       c_valid_q <= b_valid_q;
      if (d_ready)       d_valid_q <= c_valid_q;
      if (e_ready)       m_valid_q <= d_valid_q;
    end
  end

  // ---------------- stage A: input register ----------------
  logic               a_cmd_q;
  logic signed [12:0] a_accel_q;
  logic signed [18:0] a_rate_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_cmd_q   <= s_axis_tuser;
      a_accel_q <= s_axis_tdata[12:0];
      a_rate_q  <= s_axis_tdata[31:13];
    end
  end

  // ---------------- stage B: step multiply, adjusted accel ----------------
  logic               rate_neg;
  logic [18:0]        rate_mag;
  logic [36:0]        step_prod_d;
  logic signed [13:0] adj_d;

  assign rate_neg    = a_rate_q[18];
  assign rate_mag    = rate_neg ? (~a_rate_q + 19'd1) : a_rate_q;
  assign step_prod_d = 37'(rate_mag) * 37'(yaw_gain_q);
  // range stays inside 14 signed bits
  assign adj_d = {{3{accel_offset_q[10]}}, accel_offset_q} - {a_accel_q[12], a_accel_q};

  logic               b_cmd_q;
  logic               b_neg_q;
  logic [36:0]        b_prod_q;
  logic signed [13:0] b_adj_q;

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_cmd_q  <= a_cmd_q;
      b_neg_q  <= rate_neg;
      b_prod_q <= step_prod_d;
      b_adj_q  <= adj_d;
    end
  end

  // ---------------- stage C: state update ----------------
  logic signed [31:0] yaw_accum_q;
  shock_e             shock_q;
  logic               blocked_q;
  logic signed [13:0] accel_max_q;
  logic signed [13:0] accel_min_q;
  logic [3:0]         sample_cnt_q;

  logic [20:0]        step_mag;
  logic signed [32:0] step_ext;
  logic signed [32:0] yaw_sum;
  logic signed [31:0] yaw_d;
  logic               step_big;
  shock_e             shock_d;
  logic [3:0]         cnt_d;
  logic signed [13:0] max_d;
  logic signed [13:0] min_d;
  logic               blocked_d;

  assign step_mag = b_prod_q[36:16];  // truncates toward zero on the magnitude
  assign step_ext = b_neg_q ? -$signed({12'd0, step_mag}) : $signed({12'd0, step_mag});
  assign yaw_sum  = {yaw_accum_q[31], yaw_accum_q} + step_ext;
  assign step_big = step_mag > {3'd0, gyro_shock_q};

  always_comb begin
    // saturate when the carry disagrees with the sign
    if (yaw_sum[32] != yaw_sum[31]) begin
      yaw_d = yaw_sum[32] ? YawAccMin : YawAccMax;
    end else begin
      yaw_d = yaw_sum[31:0];
    end

    cnt_d = (sample_cnt_q == SampleCntMax) ? sample_cnt_q : sample_cnt_q + 4'd1;
    max_d = (b_adj_q > accel_max_q) ? b_adj_q : accel_max_q;
    min_d = (b_adj_q < accel_min_q) ? b_adj_q : accel_min_q;

    // earlier checks win: left over frontal over right
    if (step_big && !b_neg_q) begin
      shock_d = SHOCK_LEFT;
    end else if (b_adj_q < accel_shock_q) begin
      shock_d = SHOCK_FRONT;
    end else if (step_big && b_neg_q) begin
      shock_d = SHOCK_RIGHT;
    end else begin
      shock_d = shock_q;
    end

    blocked_d = blocked_q || ((cnt_d >= block_wait_q) && (max_d < accel_block_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_accum_q  <= '0;
      shock_q      <= SHOCK_NONE;
      blocked_q    <= 1'b0;
      accel_max_q  <= '0;
      accel_min_q  <= '0;
      sample_cnt_q <= '0;
    end else if (c_load) begin
      if (b_cmd_q) begin
        yaw_accum_q  <= '0;
        shock_q      <= SHOCK_NONE;
        blocked_q    <= 1'b0;
        accel_max_q  <= '0;
        accel_min_q  <= '0;
        sample_cnt_q <= '0;
      end else begin
        yaw_accum_q  <= yaw_d;
        shock_q      <= shock_d;
        blocked_q    <= blocked_d;
        accel_max_q  <= max_d;
        accel_min_q  <= min_d;
        sample_cnt_q <= cnt_d;
      end
    end
  end

  // ---------------- stage D: yaw / 100 by reciprocal ----------------
  logic        yaw_neg;
  logic [31:0] yaw_mag;
  logic [63:0] yaw_prod;

  assign yaw_neg  = yaw_accum_q[31];
  assign yaw_mag  = yaw_neg ? (~yaw_accum_q + 32'd1) : yaw_accum_q;
  assign yaw_prod = 64'(yaw_mag) * 64'(Div100Magic);

  logic [YawQuotW-1:0] d_quot_q;
  logic                d_neg_q;
  shock_e              d_shock_q;
  logic                d_blocked_q;
  logic [12:0]         d_max_q;
  logic signed [13:0]  d_min_q;

  always_ff @(posedge clk_i) begin
    if (d_load) begin
      d_quot_q    <= yaw_prod[Div100Shift +: YawQuotW];
      d_neg_q     <= yaw_neg;
      d_shock_q   <= shock_q;
      d_blocked_q <= blocked_q;
      d_max_q     <= accel_max_q[12:0];
      d_min_q     <= accel_min_q;
    end
  end

  // ---------------- stage E: output register ----------------
  result_t m_data_q;
  logic signed [25:0] yaw_deg_d;

  assign yaw_deg_d = d_neg_q ? -$signed({1'b0, d_quot_q}) : $signed({1'b0, d_quot_q});

  always_ff @(posedge clk_i) begin
    if (e_load) begin
      m_data_q.shock_code  <= d_shock_q;
      m_data_q.blocked     <= d_blocked_q;
      m_data_q.yaw_degrees <= yaw_deg_d;
      m_data_q.max_accel   <= d_max_q;
      m_data_q.min_accel   <= d_min_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------- assertions ----------------
  `IMUCD_ASSERT(a_max_nonneg, !accel_max_q[13], "accel max went negative")
  `IMUCD_ASSERT(a_min_nonpos, accel_min_q[13] || accel_min_q == '0, "accel min went positive")
  `IMUCD_ASSERT_NEXT(a_begin_clears, c_load && b_cmd_q,
    yaw_accum_q == '0 && shock_q == SHOCK_NONE && !blocked_q && sample_cnt_q == '0,
    "begin request did not clear state")
  `IMUCD_ASSERT_NEXT(a_blocked_sticky, blocked_q && !(c_load && b_cmd_q), blocked_q,
    "blocked flag dropped without begin")
  `IMUCD_ASSERT(a_ready_when_drained, !m_valid_q |-> s_axis_tready,
    "input stalled with empty output register")

endmodule

// ----- test/imucd_result_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// IMU collision detector result checker
// Watches the register port and both streams, predicts the result of every
// accepted request and compares it field by field with what comes out.
// ---------------------------------------------------------------------------
module imucd_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [imucd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [imucd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [imucd_pkg::InDataW-1:0]  s_axis_tdata,  // accel_forward[12:0], yaw_rate[31:13]
  input  logic                           s_axis_tuser,  // cmd
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [imucd_pkg::OutDataW-1:0] m_axis_tdata,  // shock_code, blocked, yaw_degrees,
                                                        // max_accel, min_accel
  output int                             fail_cnt_o,
  output int                             pending_o
);
  import imucd_pkg::*;

  // register copies
  logic signed [10:0] offset_q;
  logic signed [13:0] shock_lvl_q;
  logic signed [13:0] block_lvl_q;
  logic [17:0]        gyro_lvl_q;
  logic [17:0]        gain_q;
  logic [3:0]         wait_q;

  // tracked detector state
  longint             yaw_sum;
  shock_e             shock_q;
  logic               blocked_q;
  logic signed [13:0] accel_hi;
  logic signed [13:0] accel_lo;
  logic [3:0]         sample_cnt;

  result_t expected_q[$];
  int      fail_cnt = 0;

  assign fail_cnt_o = fail_cnt;

  initial pending_o = 0;

  task automatic clear_track();
    yaw_sum    = 0;
    shock_q    = SHOCK_NONE;
    blocked_q  = 1'b0;
    accel_hi   = '0;
    accel_lo   = '0;
    sample_cnt = '0;
  endtask

  task automatic predict_request(input logic begin_cmd, input logic [InDataW-1:0] data);
    logic signed [12:0] accel;
    logic signed [18:0] rate;
    longint             accel_l;
    longint             rate_l;
    longint             adj;
    longint             step_angle;
    longint             gyro_l;
    result_t            res;
    accel = data[12:0];
    rate  = data[31:13];
    if (begin_cmd) begin
      clear_track();
    end else begin
      accel_l = accel;
      rate_l  = rate;
      gyro_l  = gyro_lvl_q;
      adj     = -accel_l + longint'(offset_q);
      // magnitude times gain, truncated toward zero
      step_angle = ((rate_l < 0 ? -rate_l : rate_l) * longint'(gain_q)) >> 16;
      if (rate_l < 0) step_angle = -step_angle;

      yaw_sum = yaw_sum + step_angle;
      if (yaw_sum > longint'(YawAccMax)) yaw_sum = YawAccMax;
      if (yaw_sum < longint'(YawAccMin)) yaw_sum = YawAccMin;

      if (sample_cnt != SampleCntMax) sample_cnt = sample_cnt + 4'd1;
      if (adj < longint'(accel_lo)) accel_lo = 14'(adj);
      if (adj > longint'(accel_hi)) accel_hi = 14'(adj);

      // later checks win
      if (step_angle < -gyro_l)             shock_q = SHOCK_RIGHT;
      if (adj < longint'(shock_lvl_q))      shock_q = SHOCK_FRONT;
      if (step_angle > gyro_l)              shock_q = SHOCK_LEFT;

      if (sample_cnt >= wait_q && longint'(accel_hi) < longint'(block_lvl_q))
        blocked_q = 1'b1;
    end
    res.shock_code  = shock_q;
    res.blocked     = blocked_q;
    res.yaw_degrees = 26'(yaw_sum / 100);
    res.max_accel   = accel_hi[12:0];
    res.min_accel   = accel_lo;
    expected_q.push_back(res);
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    fail_cnt++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      fail_cnt++;
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      return;
    end
    want = expected_q.pop_front();
    if (got.shock_code !== want.shock_code)
      report_field("shock_code", want.shock_code, got.shock_code);
    if (got.blocked !== want.blocked)
      report_field("blocked", want.blocked, got.blocked);
    if (got.yaw_degrees !== want.yaw_degrees)
      report_field("yaw_degrees", want.yaw_degrees, got.yaw_degrees);
    if (got.max_accel !== want.max_accel)
      report_field("max_accel", want.max_accel, got.max_accel);
    if (got.min_accel !== want.min_accel)
      report_field("min_accel", want.min_accel, got.min_accel);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    = AccelOffsetRst;
      shock_lvl_q = AccelShockRst;
      block_lvl_q = AccelBlockRst;
      gyro_lvl_q  = GyroShockRst;
      gain_q      = YawGainRst;
      wait_q      = BlockWaitRst;
      clear_track();
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACCEL_OFFSET: offset_q    = cfg_data_i[10:0];
          CFG_ACCEL_SHOCK:  shock_lvl_q = cfg_data_i[13:0];
          CFG_ACCEL_BLOCK:  block_lvl_q = cfg_data_i[13:0];
          CFG_GYRO_SHOCK:   gyro_lvl_q  = cfg_data_i;
          CFG_YAW_GAIN:     gain_q      = cfg_data_i;
          CFG_BLOCK_WAIT:   wait_q      = cfg_data_i[3:0];
          default: ;  // unmapped index, dropped
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tuser, s_axis_tdata);
    end
    pending_o <= expected_q.size();
  end

endmodule

// ----- test/tb_imu_collision_detector_core.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// IMU collision detector core testbench
// Directed and random request streams with random idling on both sides,
// register settings changed between phases, results checked by a separate
// checker that predicts every result.
// ---------------------------------------------------------------------------
module tb_imu_collision_detector_core;
  import imucd_pkg::*;

  // request kinds carried on tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_BEGIN  = 1'b1;

  // pipeline holds five requests; a few spare cycles before touching registers
  localparam int DRAIN_CYCLES   = 10;
  // long receiver hold-off; the watchdog limit sits well above it plus
  // the longest random gap
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;

  localparam int RAND_CHUNKS     = 8;
  localparam int CHUNK_REQUESTS  = 115;
  localparam int SAT_REQUESTS    = 20;

  localparam int GAIN_MAX = 262143;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx    = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;
  logic                s_tvalid   = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata    = '0;
  logic                s_tuser    = 1'b0;
  logic                m_tvalid;
  logic                m_tready   = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int fail_cnt;
  int pending;
  int stall_cycles = 0;

  // shared between the sender and the receiver processes
  bit burst_mode    = 1'b0;  // no idling on either side
  bit hold_off_req  = 1'b0;  // receiver to stall for a long stretch

  always #5 clk = ~clk;

  imu_collision_detector_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  imucd_result_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  // -------------------------------------------------------------------------
  // random shapes
  // -------------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (burst_mode)  return 0;
    if (sel < 55)    return 0;
    if (sel < 85)    return $urandom_range(1, 3);
    if (sel < 97)    return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // forward acceleration: full range with extra weight on the ends and on
  // values near the usual thresholds
  function automatic int pick_accel();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return -4096;
      1:       return 4095;
      2, 3:    return int'($urandom_range(0, 600)) - 300;
      default: return int'($urandom_range(0, 8191)) - 4096;
    endcase
  endfunction

  // yaw rate: full range, ends, and small rates that land near the
  // side-shock level for moderate gains
  function automatic int pick_rate();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return 200000;
      1:       return -200000;
      2, 3:    return int'($urandom_range(0, 10000)) - 5000;
      default: return int'($urandom_range(0, 400000)) - 200000;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // sender side
  // -------------------------------------------------------------------------

  // offer one request, hold it until taken; valid stays high into the next
  // request when there is no gap
  task automatic send_request(input logic cmd, input int accel, input int rate);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {19'(rate), 13'(accel)};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait for every outstanding result, plus a margin
  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write per clock; write enable is lowered by the caller
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CfgDataW'(value);
    @(posedge clk);
  endtask

  // full register set, followed by a write to an unmapped index that the
  // block has to drop
  task automatic write_regs(input int offset, input int shock_lvl, input int block_lvl,
                            input int gyro_lvl, input int gain, input int wait_n);
    put_reg(CFG_ACCEL_OFFSET, offset);
    put_reg(CFG_ACCEL_SHOCK,  shock_lvl);
    put_reg(CFG_ACCEL_BLOCK,  block_lvl);
    put_reg(CFG_GYRO_SHOCK,   gyro_lvl);
    put_reg(CFG_YAW_GAIN,     gain);
    put_reg(CFG_BLOCK_WAIT,   wait_n);
    put_reg(CfgIdxW'(int'(CFG_BLOCK_WAIT) + int'($urandom_range(1, 2))),
            $urandom_range(0, GAIN_MAX));
    cfg_we <= 1'b0;
  endtask

  // random settings; the ends of the level and gain ranges come up regularly
  task automatic new_settings(input bit max_gain);
    int offset, shock_lvl, block_lvl, gyro_lvl, gain;
    offset = int'($urandom_range(0, 2047)) - 1024;
    case ($urandom_range(0, 4))
      0:       shock_lvl = -5120;
      1:       shock_lvl = 5119;
      default: shock_lvl = int'($urandom_range(0, 1000)) - 700;
    endcase
    case ($urandom_range(0, 4))
      0:       block_lvl = -5120;
      1:       block_lvl = 5119;
      default: block_lvl = int'($urandom_range(0, 600)) - 200;
    endcase
    case ($urandom_range(0, 4))
      0:       gyro_lvl = 0;
      1:       gyro_lvl = 200000;
      default: gyro_lvl = $urandom_range(0, 20000);
    endcase
    case ($urandom_range(0, 9))
      0:       gain = 0;
      1:       gain = GAIN_MAX;
      2, 3, 4: gain = $urandom_range(0, GAIN_MAX);
      default: gain = $urandom_range(0, 8000);
    endcase
    if (max_gain) gain = GAIN_MAX;
    write_regs(offset, shock_lvl, block_lvl, gyro_lvl, gain, $urandom_range(0, 15));
  endtask

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset settings (gain 3277, side level 100, front -200,
    //     block level 40, wait 6)
    send_request(CMD_BEGIN, 0, 0);
    send_request(CMD_SAMPLE, -4096, 200000);   // left turn shock, max adj
    send_request(CMD_SAMPLE, 4095, -200000);   // right then frontal, frontal wins
    send_request(CMD_SAMPLE, 0, -200000);      // right shock overrides
    send_request(CMD_SAMPLE, 0, 0);
    send_request(CMD_SAMPLE, 1, 1);
    send_request(CMD_SAMPLE, -1, -1);
    send_request(CMD_BEGIN, 4095, -200000);    // clears, data ignored
    repeat (7) send_request(CMD_SAMPLE, 0, 0); // blocked after the wait
    drain_pipe();

    // --- register extremes, zero wait: blocked check from the first sample
    write_regs(-1024, -5120, 5119, 0, GAIN_MAX, 0);
    send_request(CMD_BEGIN, 0, 0);
    send_request(CMD_SAMPLE, 4095, -200000);
    send_request(CMD_SAMPLE, -4096, 200000);
    send_request(CMD_SAMPLE, 0, 0);            // zero step is not above zero level
    send_request(CMD_SAMPLE, 0, 1);
    send_request(CMD_SAMPLE, 0, -1);
    drain_pipe();

    // --- opposite extremes, zero gain, longest wait
    write_regs(1023, 5119, -5120, 200000, 0, 15);
    send_request(CMD_BEGIN, -4096, 200000);
    send_request(CMD_SAMPLE, -4096, 199999);
    send_request(CMD_SAMPLE, 4095, -1);

    // --- random chunks, each under fresh settings; one chunk runs without
    //     idling, another has the receiver hold off for a long stretch
    for (int chunk = 0; chunk < RAND_CHUNKS; chunk++) begin
      drain_pipe();
      new_settings(1'b0);
      burst_mode = (chunk == 5);
      if (chunk == 2) hold_off_req = 1'b1;
      if ($urandom_range(0, 3) != 0) send_request(CMD_BEGIN, pick_accel(), pick_rate());
      for (int n = 0; n < CHUNK_REQUESTS; n++) begin
        if ($urandom_range(0, 24) == 0)
          send_request(CMD_BEGIN, pick_accel(), pick_rate());
        else
          send_request(CMD_SAMPLE, pick_accel(), pick_rate());
      end
      burst_mode = 1'b0;
    end

    // --- full gain: large steps in one direction, then mixed steps back,
    //     once each way
    drain_pipe();
    new_settings(1'b1);
    send_request(CMD_BEGIN, 0, 0);
    for (int n = 0; n < SAT_REQUESTS; n++)
      send_request(CMD_SAMPLE, pick_accel(), $urandom_range(190000, 200000));
    for (int n = 0; n < 40; n++)
      send_request(CMD_SAMPLE, pick_accel(), -int'($urandom_range(0, 200000)));
    send_request(CMD_BEGIN, 0, 0);
    for (int n = 0; n < SAT_REQUESTS; n++)
      send_request(CMD_SAMPLE, pick_accel(), -int'($urandom_range(190000, 200000)));
    for (int n = 0; n < 40; n++)
      send_request(CMD_SAMPLE, pick_accel(), $urandom_range(0, 200000));

    drain_pipe();
    if (fail_cnt == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // -------------------------------------------------------------------------
  // receiver side: random ready pattern, long hold-off on request
  // -------------------------------------------------------------------------
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (burst_mode) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // watchdog: too long without any request or result moving
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/imucd_pkg.sv
hw/rtl/imu_collision_detector_core.sv
test/imucd_result_checker.sv
test/tb_imu_collision_detector_core.sv
